@@ rtl/rsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the RPN stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int VAL_W       = 32;
	localparam int FRAC_W      = 16;
	localparam int DIV_STEPS   = VAL_W;
	localparam int CNT_W       = $clog2(DIV_STEPS);
	localparam int REQ_W       = 3;
	localparam int STAT_W      = 3;

	localparam logic [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH = 3'd0,
		REQ_ADD  = 3'd1,
		REQ_SUB  = 3'd2,
		REQ_MUL  = 3'd3,
		REQ_DIV  = 3'd4,
		REQ_PEEK = 3'd5
	} req_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 3'd0,
		ST_FEW  = 3'd1,
		ST_FULL = 3'd2,
		ST_DIVZ = 3'd3,
		ST_SAT  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LATCH,
		DP_PUSH,
		DP_ERR,
		DP_RD_T,
		DP_RD_S,
		DP_LOAD_S,
		DP_ADDSUB,
		DP_MUL,
		DP_MUL_FIN,
		DP_DIV_ZERO,
		DP_DIV_SAT,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_DIV_FIN,
		DP_PEEK
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t err;
		logic    wb;
		logic    out_load;
	} rsc_cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             sp_zero;
		logic             sp_lt2;
		logic             sp_full;
		logic             t_zero;
		logic             div_ovf;
	} rsc_sts_t;

endpackage

@@ rtl/rpn_stack_calculator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish evaluator over a stack of signed Q16.16 values.
// Each word is latched and checked; arithmetic then fetches both operands,
// executes and writes back. Divide runs 32 steps of the bit-serial divider
// except for a zero divisor or an out-of-range quotient. One word is processed
// at a time; the next is taken the cycle after the result enters the output
// register, and none is taken while the output stalls.
// Reset empties the stack; stored entries are not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] operand_value
	input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] result_value, [36:32] stack_count
	output logic [2:0]  m_axis_tuser   // [2:0] status
);
	import rsc_pkg::*;

	rsc_cmd_t         cmd;
	rsc_sts_t         sts;
	logic [VAL_W-1:0] res_value;
	status_t          res_status;
	logic [SP_W-1:0]  res_count;
	logic             out_free;
	logic             tvalid_q;
	logic [39:0]      tdata_q;
	logic [2:0]       tuser_q;

	assign out_free = !tvalid_q || m_axis_tready;

	rsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_req     (s_axis_tuser),
		.in_operand (s_axis_tdata),
		.sts        (sts),
		.res_value  (res_value),
		.res_status (res_status),
		.res_count  (res_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tdata_q <= {3'b000, 5'(res_count), res_value};
			tuser_q <= res_status;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second word taken while one is in flight");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[36:32] <= 5'(STACK_DEPTH)))
		else $error("stack count beyond depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && res_status == ST_FULL) |-> (res_count == SP_W'(STACK_DEPTH)))
		else $error("stack full reported on a stack with room");

endmodule

@@ rtl/rsc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_datapath
// Operand stack, fetch registers, multiplier and bit-serial divider.
// ----------------------------------------------------------------------------
module rsc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsc_pkg::rsc_cmd_t           cmd,
	input  logic [rsc_pkg::REQ_W-1:0]   in_req,
	input  logic [rsc_pkg::VAL_W-1:0]   in_operand,
	output rsc_pkg::rsc_sts_t           sts,
	output logic [rsc_pkg::VAL_W-1:0]   res_value,
	output rsc_pkg::status_t            res_status,
	output logic [rsc_pkg::SP_W-1:0]    res_count
);
	import rsc_pkg::*;

	logic [VAL_W-1:0]   mem [STACK_DEPTH];
	logic [REQ_W-1:0]   req_q;
	logic [VAL_W-1:0]   operand_q;
	logic [SP_W-1:0]    sp_q;
	logic [VAL_W-1:0]   rdata_q;
	logic [VAL_W-1:0]   t_q;
	logic [VAL_W-1:0]   s_q;
	logic [2*VAL_W-1:0] prod_q;
	logic [VAL_W-1:0]   rem_q;
	logic [VAL_W-1:0]   quo_q;
	logic [VAL_W-1:0]   res_q;
	status_t            st_q;

	logic [ADDR_W-1:0]         raddr;
	logic [ADDR_W-1:0]         wb_addr;
	logic [VAL_W-1:0]          abs_s;
	logic [VAL_W-1:0]          abs_t;
	logic                      neg;
	logic [VAL_W:0]            sum;
	logic [2*VAL_W-FRAC_W-1:0] mq;
	logic                      mq_ovf;
	logic [VAL_W:0]            r2;
	logic [VAL_W:0]            r2_sub;
	logic                      ge;

	always_comb begin
		raddr   = (cmd.op == DP_RD_S) ? ADDR_W'(sp_q - SP_W'(2)) : ADDR_W'(sp_q - SP_W'(1));
		wb_addr = ADDR_W'(sp_q - SP_W'(2));
		abs_s   = s_q[VAL_W-1] ? (~s_q + 1'b1) : s_q;
		abs_t   = t_q[VAL_W-1] ? (~t_q + 1'b1) : t_q;
		neg     = s_q[VAL_W-1] ^ t_q[VAL_W-1];
		if (req_q == REQ_SUB) begin
			sum = {s_q[VAL_W-1], s_q} - {t_q[VAL_W-1], t_q};
		end else begin
			sum = {s_q[VAL_W-1], s_q} + {t_q[VAL_W-1], t_q};
		end
		mq     = prod_q[2*VAL_W-1:FRAC_W]
			+ (2*VAL_W-FRAC_W)'(prod_q[2*VAL_W-1] && (|prod_q[FRAC_W-1:0]));
		mq_ovf = !((&mq[2*VAL_W-FRAC_W-1:VAL_W-1]) || !(|mq[2*VAL_W-FRAC_W-1:VAL_W-1]));
		r2     = {rem_q, quo_q[VAL_W-1]};
		r2_sub = r2 - {1'b0, abs_t};
		ge     = r2 >= {1'b0, abs_t};
	end

	assign sts.req     = req_q;
	assign sts.sp_zero = (sp_q == '0);
	assign sts.sp_lt2  = (sp_q < SP_W'(2));
	assign sts.sp_full = (sp_q >= SP_W'(STACK_DEPTH));
	assign sts.t_zero  = (t_q == '0);
	assign sts.div_ovf = ({{(VAL_W-FRAC_W){1'b0}}, abs_s[VAL_W-1:FRAC_W]} >= abs_t);

	assign res_value  = res_q;
	assign res_status = st_q;
	assign res_count  = sp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.op == DP_PUSH) begin
			sp_q <= sp_q + 1'b1;
		end else if (cmd.wb) begin
			sp_q <= sp_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (cmd.op == DP_PUSH) begin
			mem[ADDR_W'(sp_q)] <= operand_q;
		end else if (cmd.wb) begin
			mem[wb_addr] <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LATCH: begin
				req_q     <= in_req;
				operand_q <= in_operand;
			end
			DP_PUSH: begin
				res_q <= operand_q;
				st_q  <= ST_OK;
			end
			DP_ERR: begin
				res_q <= '0;
				st_q  <= cmd.err;
			end
			DP_RD_S: begin
				t_q <= rdata_q;
			end
			DP_LOAD_S: begin
				s_q <= rdata_q;
			end
			DP_ADDSUB: begin
				if (sum[VAL_W] != sum[VAL_W-1]) begin
					res_q <= sum[VAL_W] ? Q_MIN : Q_MAX;
					st_q  <= ST_SAT;
				end else begin
					res_q <= sum[VAL_W-1:0];
					st_q  <= ST_OK;
				end
			end
			DP_MUL: begin
				prod_q <= $signed({{VAL_W{s_q[VAL_W-1]}}, s_q})
					* $signed({{VAL_W{t_q[VAL_W-1]}}, t_q});
			end
			DP_MUL_FIN: begin
				if (mq_ovf) begin
					res_q <= mq[2*VAL_W-FRAC_W-1] ? Q_MIN : Q_MAX;
					st_q  <= ST_SAT;
				end else begin
					res_q <= mq[VAL_W-1:0];
					st_q  <= ST_OK;
				end
			end
			DP_DIV_ZERO: begin
				if (s_q == '0) begin
					res_q <= '0;
				end else begin
					res_q <= s_q[VAL_W-1] ? Q_MIN : Q_MAX;
				end
				st_q <= ST_DIVZ;
			end
			DP_DIV_SAT: begin
				res_q <= neg ? Q_MIN : Q_MAX;
				st_q  <= ST_SAT;
			end
			DP_DIV_INIT: begin
				rem_q <= {{(VAL_W-FRAC_W){1'b0}}, abs_s[VAL_W-1:FRAC_W]};
				quo_q <= {abs_s[FRAC_W-1:0], {(VAL_W-FRAC_W){1'b0}}};
			end
			DP_DIV_STEP: begin
				rem_q <= ge ? r2_sub[VAL_W-1:0] : r2[VAL_W-1:0];
				quo_q <= {quo_q[VAL_W-2:0], ge};
			end
			DP_DIV_FIN: begin
				if (!neg) begin
					res_q <= quo_q[VAL_W-1] ? Q_MAX : quo_q;
					st_q  <= quo_q[VAL_W-1] ? ST_SAT : ST_OK;
				end else if (quo_q > Q_MIN) begin
					res_q <= Q_MIN;
					st_q  <= ST_SAT;
				end else begin
					res_q <= ~quo_q + 1'b1;
					st_q  <= ST_OK;
				end
			end
			DP_PEEK: begin
				res_q <= rdata_q;
				st_q  <= ST_OK;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/rsc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_ctrl
// Sequencer that fetches operands, runs the operation and writes back.
// ----------------------------------------------------------------------------
module rsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_free,
	input  rsc_pkg::rsc_sts_t sts,
	output rsc_pkg::rsc_cmd_t cmd
);
	import rsc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_FETCH_S,
		S_FETCH_W,
		S_EXEC,
		S_MUL_W,
		S_DIV_RUN,
		S_DIV_END,
		S_WRITE_BACK,
		S_PEEK_W,
		S_DONE
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '{op: DP_NOP, err: ST_OK, wb: 1'b0, out_load: 1'b0};
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = DP_LATCH;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_DONE;
				case (sts.req)
					REQ_PUSH: begin
						if (sts.sp_full) begin
							cmd.op  = DP_ERR;
							cmd.err = ST_FULL;
						end else begin
							cmd.op = DP_PUSH;
						end
					end
					REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
						if (sts.sp_lt2) begin
							cmd.op  = DP_ERR;
							cmd.err = ST_FEW;
						end else begin
							cmd.op  = DP_RD_T;
							state_d = S_FETCH_S;
						end
					end
					REQ_PEEK: begin
						if (sts.sp_zero) begin
							cmd.op  = DP_ERR;
							cmd.err = ST_FEW;
						end else begin
							cmd.op  = DP_RD_T;
							state_d = S_PEEK_W;
						end
					end
					default: begin
						cmd.op  = DP_ERR;
						cmd.err = ST_OK;
					end
				endcase
			end
			S_FETCH_S: begin
				cmd.op  = DP_RD_S;
				state_d = S_FETCH_W;
			end
			S_FETCH_W: begin
				cmd.op  = DP_LOAD_S;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_WRITE_BACK;
				case (sts.req)
					REQ_ADD, REQ_SUB: begin
						cmd.op = DP_ADDSUB;
					end
					REQ_MUL: begin
						cmd.op  = DP_MUL;
						state_d = S_MUL_W;
					end
					REQ_DIV: begin
						if (sts.t_zero) begin
							cmd.op = DP_DIV_ZERO;
						end else if (sts.div_ovf) begin
							cmd.op = DP_DIV_SAT;
						end else begin
							cmd.op  = DP_DIV_INIT;
							state_d = S_DIV_RUN;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_MUL_W: begin
				cmd.op  = DP_MUL_FIN;
				state_d = S_WRITE_BACK;
			end
			S_DIV_RUN: begin
				cmd.op = DP_DIV_STEP;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_DIV_END;
				end
			end
			S_DIV_END: begin
				cmd.op  = DP_DIV_FIN;
				state_d = S_WRITE_BACK;
			end
			S_WRITE_BACK: begin
				cmd.wb  = 1'b1;
				state_d = S_DONE;
			end
			S_PEEK_W: begin
				cmd.op  = DP_PEEK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

@@ bench/rpn_stack_calculator_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_check
// Watches both stream channels of the RPN stack calculator. Each accepted
// input word is run through a local Q16.16 stack evaluator, and the
// predicted result word is compared field by field with the next output word.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] operand_value
	input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,  // [31:0] result_value, [36:32] stack_count
	input  logic [2:0]  m_axis_tuser,  // [2:0] status
	output int          fail_count,
	output int          outstanding,
	output int          results_checked,
	output int          flagged_count
);
	import rsc_pkg::*;

	localparam longint Q_TOP = 64'sd2147483647;
	localparam longint Q_BOT = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] value;
		status_t     status;
		logic [4:0]  depth;
	} calc_word_t;

	logic [31:0] operand_stack [STACK_DEPTH];
	int          stack_depth = 0;
	calc_word_t  expected_q [$];
	int          fails = 0;
	int          checked = 0;
	int          flagged = 0;

	initial begin
		fail_count      = 0;
		outstanding     = 0;
		results_checked = 0;
		flagged_count   = 0;
	end

	function automatic longint clamp_q(input longint v, inout bit sat);
		if (v > Q_TOP) begin
			sat = 1'b1;
			return Q_TOP;
		end
		if (v < Q_BOT) begin
			sat = 1'b1;
			return Q_BOT;
		end
		return v;
	endfunction

	function automatic calc_word_t eval_word(input logic [2:0] req, input logic [31:0] operand);
		calc_word_t o;
		longint     s;
		longint     t;
		longint     r;
		bit         sat;
		o.value  = '0;
		o.status = ST_OK;
		sat      = 1'b0;
		r        = 0;
		case (req)
			REQ_PUSH: begin
				if (stack_depth < STACK_DEPTH) begin
					operand_stack[stack_depth] = operand;
					stack_depth++;
					o.value = operand;
				end else begin
					o.status = ST_FULL;
				end
			end
			REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
				if (stack_depth < 2) begin
					o.status = ST_FEW;
				end else begin
					t = longint'($signed(operand_stack[stack_depth-1]));
					s = longint'($signed(operand_stack[stack_depth-2]));
					case (req)
						REQ_ADD: r = clamp_q(s + t, sat);
						REQ_SUB: r = clamp_q(s - t, sat);
						REQ_MUL: r = clamp_q((s * t) / 65536, sat);
						default: begin
							if (t == 0) begin
								r = (s > 0) ? Q_TOP : ((s < 0) ? Q_BOT : 0);
								o.status = ST_DIVZ;
							end else begin
								r = clamp_q((s * 65536) / t, sat);
							end
						end
					endcase
					if (sat)
						o.status = ST_SAT;
					stack_depth--;
					operand_stack[stack_depth-1] = r[31:0];
					o.value = r[31:0];
				end
			end
			REQ_PEEK: begin
				if (stack_depth == 0)
					o.status = ST_FEW;
				else
					o.value = operand_stack[stack_depth-1];
			end
			default: ;
		endcase
		o.depth = stack_depth[4:0];
		return o;
	endfunction

	always @(posedge clk) begin : watch
		calc_word_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result word: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
					fails++;
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (want.status != ST_OK)
						flagged++;
					if (m_axis_tdata[31:0] !== want.value) begin
						$error("result_value: expected %h, got %h", want.value, m_axis_tdata[31:0]);
						fails++;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
						fails++;
					end
					if (m_axis_tdata[36:32] !== want.depth) begin
						$error("stack_count: expected %0d, got %0d", want.depth, m_axis_tdata[36:32]);
						fails++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(eval_word(s_axis_tuser, s_axis_tdata));
		end
		fail_count      <= fails;
		outstanding     <= expected_q.size();
		results_checked <= checked;
		flagged_count   <= flagged;
	end

endmodule

@@ bench/rpn_stack_calculator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_test
// Drives the RPN stack calculator with a directed set of edge cases and then
// random push/operation sequences under four handshake mixes, with a long
// output hold-off; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_test;
	import rsc_pkg::*;

	localparam int LIMIT       = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_WORDS  = 1150;
	localparam int N_PHASES    = 4;
	localparam int N_DIRECTED  = 25;

	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;

	localparam int SEND_IDLE  [N_PHASES] = '{0, 81, 0, 36};
	localparam int RECV_STALL [N_PHASES] = '{0, 0, 81, 36};

	localparam logic [2:0] DIR_REQ [N_DIRECTED] = '{
		REQ_PEEK, REQ_ADD, REQ_PUSH, REQ_SUB, REQ_PEEK,
		REQ_PUSH, REQ_ADD, REQ_PUSH, REQ_SUB, REQ_PUSH,
		REQ_DIV, REQ_PUSH, REQ_PUSH, REQ_DIV, REQ_PUSH,
		REQ_DIV, REQ_MUL, REQ_PUSH, REQ_PUSH, REQ_DIV,
		REQ_SPARE_A, REQ_SPARE_B, REQ_MUL, REQ_PUSH, REQ_SUB
	};
	localparam logic [31:0] DIR_VAL [N_DIRECTED] = '{
		32'h0, 32'h0, Q_MAX, 32'h0, 32'h0,
		Q_MAX, 32'h0, Q_MIN, 32'h0, 32'h0,
		32'h0, Q_MIN, 32'h0, 32'h0, 32'hFFFF_0000,
		32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
		32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFE_8000, 32'h0
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	int fail_count;
	int outstanding;
	int results_checked;
	int flagged_count;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_go = 1'b0;
	int hold_left = 0;
	int cycles = 0;
	int depth = 0;
	int fill_left = 0;
	int n_push = 0;
	int n_arith = 0;
	int n_peek = 0;
	int n_spare = 0;

	always #4 clk = ~clk;

	rpn_stack_calculator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	rpn_stack_calculator_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.flagged_count   (flagged_count)
	);

	// hold off the output for a long stretch on request, else stall at random
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(5))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return 32'h0;
					3: return 32'h0001_0000;
					4: return 32'hFFFF_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1, 2, 3, 4: return $urandom_range(32'h7_FFFF) - 32'h4_0000;
			5, 6, 7: return v;
			8: return 32'h0;
			default: return {{8{v[23]}}, v[23:0]};
		endcase
	endfunction

	task automatic next_word(output logic [2:0] req, output logic [31:0] val);
		int r;
		int push_pct;
		val = pick_value();
		r = $urandom_range(99);
		if (fill_left > 0) begin
			fill_left--;
			req = REQ_PUSH;
		end else if (r < 3) begin
			req = $urandom_range(1) ? REQ_SPARE_B : REQ_SPARE_A;
		end else if (r < 8) begin
			req = REQ_PEEK;
		end else if (r < 10) begin
			// run the stack into its limit and push past it
			fill_left = STACK_DEPTH + 1 - depth;
			req = REQ_PUSH;
		end else begin
			push_pct = (depth < 2) ? 80 : ((depth > 12) ? 20 : 50);
			if ($urandom_range(99) < push_pct)
				req = REQ_PUSH;
			else
				req = 3'($urandom_range(REQ_ADD, REQ_DIV));
		end
	endtask

	task automatic send_word(input logic [2:0] req, input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			s_axis_tuser  <= 3'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= val;
		s_axis_tuser  <= req;
		do @(posedge clk); while (!s_axis_tready);
		case (req)
			REQ_PUSH: begin
				n_push++;
				if (depth < STACK_DEPTH)
					depth++;
			end
			REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
				n_arith++;
				if (depth >= 2)
					depth--;
			end
			REQ_PEEK: n_peek++;
			default: n_spare++;
		endcase
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		logic [2:0]  req;
		logic [31:0] val;
		int          sent;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(DIR_REQ[i], DIR_VAL[i]);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			send_idle_pct  <= SEND_IDLE[ph];
			recv_stall_pct <= RECV_STALL[ph];
			fill_left = STACK_DEPTH + 1 - depth;
			sent = 0;
			while (sent < RAND_WORDS / N_PHASES) begin
				if (ph == 0 && sent == 40)
					hold_go <= 1'b1;
				next_word(req, val);
				send_word(req, val);
				if (req != REQ_SPARE_A && req != REQ_SPARE_B)
					sent++;
			end
			drain();
		end

		repeat (60) @(posedge clk);
		$display("Drove %0d words: %0d push, %0d arithmetic, %0d peek, %0d unused selector.",
			n_push + n_arith + n_peek + n_spare, n_push, n_arith, n_peek, n_spare);
		$display("Checked %0d results, %0d with an error, divide-by-zero or saturation status.",
			results_checked, flagged_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
